### design/sgdr_pkg.sv
`default_nettype none
package sgdr_pkg;

    localparam int GRID_DIM = 32;
    localparam int CELLS    = GRID_DIM * GRID_DIM;
    localparam int DIM_W    = $clog2(GRID_DIM);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int HEIGHT_W = 4;
    localparam int COUNT_W  = 24;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [HEIGHT_W-1:0] TOPPLE_AT  = HEIGHT_W'(4);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_DROP  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Neighbor order used while distributing the grains of one toppling.
    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] row;
        logic [4:0] col;
        logic [1:0] height_in;
    } req_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height_out;
        logic [COUNT_W-1:0]  topple_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DROP_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_NB_RD,
        ST_NB_WR,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                    input logic [DIM_W-1:0] c);
        return ADDR_W'(r * GRID_DIM + c);
    endfunction

endpackage
`default_nettype wire

### design/sgdr_ram.sv
`default_nettype none
module sgdr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### design/sandpile_grain_drop_relax_unit.sv
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   sgdr_pkg::req_t (mode, row, col, height_in)
// rsp      out        rsp_valid/rsp_ready   sgdr_pkg::rsp_t (height_out, topple_count)
//
// After reset the grid memory is cleared one cell per cycle, all CELLS = 1024 cells;
// req_ready stays low for that time.
// A write or an out-of-grid item goes from IDLE to DONE; a read passes through READ.
// A drop writes the cell, then sweeps the grid, reading and checking each cell;
// a toppling cell updates each neighbor in the grid. At least one sweep is run.
// One item is worked on at a time; a finished result waits in the output register
// while the next transfer is already accepted.
module sandpile_grain_drop_relax_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire sgdr_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output sgdr_pkg::rsp_t       rsp
);

    sgdr_pkg::state_t state_reg, state_next;

    logic [sgdr_pkg::DIM_W-1:0]    r_reg, r_next;
    logic [sgdr_pkg::DIM_W-1:0]    c_reg, c_next;
    logic [1:0]                    nb_reg, nb_next;
    logic                          again_reg, again_next;
    logic [sgdr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [sgdr_pkg::HEIGHT_W-1:0] hres_reg, hres_next;
    logic [sgdr_pkg::ADDR_W-1:0]   drop_addr_reg, drop_addr_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    sgdr_pkg::rsp_t                rsp_reg, rsp_next;

    logic                          mem_we;
    logic [sgdr_pkg::ADDR_W-1:0]   mem_waddr;
    logic [sgdr_pkg::HEIGHT_W-1:0] mem_wdata;
    logic [sgdr_pkg::ADDR_W-1:0]   mem_raddr;
    logic [sgdr_pkg::HEIGHT_W-1:0] mem_rdata;

    logic                          accept;
    logic                          req_in_grid;
    logic [sgdr_pkg::ADDR_W-1:0]   req_addr;
    logic [sgdr_pkg::ADDR_W-1:0]   scan_addr;
    logic                          last_cell;
    logic                          last_col;
    logic                          nb_valid;
    logic [sgdr_pkg::ADDR_W-1:0]   nb_addr;
    logic                          unstable;
    logic                          rsp_free;

    sgdr_ram #(
        .WIDTH (sgdr_pkg::HEIGHT_W),
        .DEPTH (sgdr_pkg::CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == sgdr_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Row and column are compared at full width before they are cut to grid width.
    assign req_in_grid = (32'(req.row) < 32'(sgdr_pkg::GRID_DIM)) &&
                         (32'(req.col) < 32'(sgdr_pkg::GRID_DIM));
    assign req_addr    = sgdr_pkg::cell_addr(sgdr_pkg::DIM_W'(req.row),
                                             sgdr_pkg::DIM_W'(req.col));
    assign scan_addr   = sgdr_pkg::cell_addr(r_reg, c_reg);
    assign last_col    = (c_reg == sgdr_pkg::DIM_W'(sgdr_pkg::GRID_DIM - 1));
    assign last_cell   = last_col && (r_reg == sgdr_pkg::DIM_W'(sgdr_pkg::GRID_DIM - 1));
    assign unstable    = (mem_rdata >= sgdr_pkg::TOPPLE_AT);

    // Neighbor of the cell under the scan pointer, selected by the neighbor counter.
    always_comb
    begin
        nb_valid = 1'b0;
        nb_addr  = scan_addr;
        unique case (nb_reg)
            sgdr_pkg::NB_LEFT:
            begin
                nb_valid = (c_reg != '0);
                nb_addr  = sgdr_pkg::cell_addr(r_reg, c_reg - 1'b1);
            end
            sgdr_pkg::NB_RIGHT:
            begin
                nb_valid = !last_col;
                nb_addr  = sgdr_pkg::cell_addr(r_reg, c_reg + 1'b1);
            end
            sgdr_pkg::NB_UP:
            begin
                nb_valid = (r_reg != '0);
                nb_addr  = sgdr_pkg::cell_addr(r_reg - 1'b1, c_reg);
            end
            sgdr_pkg::NB_DOWN:
            begin
                nb_valid = (r_reg != sgdr_pkg::DIM_W'(sgdr_pkg::GRID_DIM - 1));
                nb_addr  = sgdr_pkg::cell_addr(r_reg + 1'b1, c_reg);
            end
            default:
            begin
                nb_valid = 1'b0;
                nb_addr  = scan_addr;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sgdr_pkg::ST_CLEAR:
            begin
                if (last_cell)
                begin
                    state_next = sgdr_pkg::ST_IDLE;
                end
            end
            sgdr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_in_grid && req.mode == sgdr_pkg::MODE_DROP)
                    begin
                        state_next = sgdr_pkg::ST_DROP_WR;
                    end
                    else if (req_in_grid && req.mode == sgdr_pkg::MODE_READ)
                    begin
                        state_next = sgdr_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = sgdr_pkg::ST_DONE;
                    end
                end
            end
            sgdr_pkg::ST_READ:    state_next = sgdr_pkg::ST_DONE;
            sgdr_pkg::ST_DROP_WR: state_next = sgdr_pkg::ST_SCAN_RD;
            sgdr_pkg::ST_SCAN_RD: state_next = sgdr_pkg::ST_SCAN_CHK;
            sgdr_pkg::ST_SCAN_CHK:
            begin
                if (unstable)
                begin
                    state_next = sgdr_pkg::ST_NB_RD;
                end
                else if (last_cell && !again_reg)
                begin
                    state_next = sgdr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sgdr_pkg::ST_SCAN_RD;
                end
            end
            sgdr_pkg::ST_NB_RD:
            begin
                if (nb_valid)
                begin
                    state_next = sgdr_pkg::ST_NB_WR;
                end
                else if (nb_reg != sgdr_pkg::NB_DOWN)
                begin
                    state_next = sgdr_pkg::ST_NB_RD;
                end
                else
                begin
                    // A toppling always marks another sweep, so the scan goes on.
                    state_next = sgdr_pkg::ST_SCAN_RD;
                end
            end
            sgdr_pkg::ST_NB_WR:
            begin
                if (nb_reg != sgdr_pkg::NB_DOWN)
                begin
                    state_next = sgdr_pkg::ST_NB_RD;
                end
                else
                begin
                    state_next = sgdr_pkg::ST_SCAN_RD;
                end
            end
            sgdr_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = sgdr_pkg::ST_IDLE;
                end
            end
            default: state_next = sgdr_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and datapath registers.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = scan_addr;
        mem_wdata      = '0;
        mem_raddr      = scan_addr;
        r_next         = r_reg;
        c_next         = c_reg;
        nb_next        = nb_reg;
        again_next     = again_reg;
        count_next     = count_reg;
        hres_next      = hres_reg;
        drop_addr_next = drop_addr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            sgdr_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_addr;
                mem_wdata = '0;
                if (last_col)
                begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            sgdr_pkg::ST_IDLE:
            begin
                mem_raddr      = req_addr;
                drop_addr_next = req_addr;
                count_next     = '0;
                hres_next      = '0;
                r_next         = '0;
                c_next         = '0;
                again_next     = 1'b0;
                if (accept && req_in_grid && req.mode == sgdr_pkg::MODE_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = req_addr;
                    mem_wdata = sgdr_pkg::HEIGHT_W'(req.height_in);
                end
            end
            sgdr_pkg::ST_READ:
            begin
                hres_next = mem_rdata;
            end
            sgdr_pkg::ST_DROP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = drop_addr_reg;
                mem_wdata = mem_rdata + 1'b1;
            end
            sgdr_pkg::ST_SCAN_RD:
            begin
                mem_raddr = scan_addr;
            end
            sgdr_pkg::ST_SCAN_CHK:
            begin
                if (unstable)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = scan_addr;
                    mem_wdata  = mem_rdata - sgdr_pkg::TOPPLE_AT;
                    again_next = 1'b1;
                    nb_next    = sgdr_pkg::NB_LEFT;
                    if (count_reg != sgdr_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (last_cell)
                begin
                    // End of a sweep: start another one if anything toppled.
                    r_next     = '0;
                    c_next     = '0;
                    again_next = 1'b0;
                end
                else if (last_col)
                begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            sgdr_pkg::ST_NB_RD:
            begin
                mem_raddr = nb_addr;
                if (!nb_valid)
                begin
                    nb_next = nb_reg + 1'b1;
                end
            end
            sgdr_pkg::ST_NB_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = nb_addr;
                mem_wdata = mem_rdata + 1'b1;
                nb_next   = nb_reg + 1'b1;
            end
            sgdr_pkg::ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.height_out   = hres_reg;
                    rsp_next.topple_count = count_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        // Leaving the neighbor loop after the last neighbor moves the scan on.
        if ((state_reg == sgdr_pkg::ST_NB_WR ||
             (state_reg == sgdr_pkg::ST_NB_RD && !nb_valid)) &&
            nb_reg == sgdr_pkg::NB_DOWN)
        begin
            if (last_cell)
            begin
                r_next     = '0;
                c_next     = '0;
                again_next = 1'b0;
            end
            else if (last_col)
            begin
                c_next = '0;
                r_next = r_reg + 1'b1;
            end
            else
            begin
                c_next = c_reg + 1'b1;
            end
        end
    end

    // A toppling at the very last cell still needs a new sweep; the sweep that
    // restarts from cell 0 keeps the flag set so it is not lost.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgdr_pkg::ST_CLEAR;
            r_reg         <= '0;
            c_reg         <= '0;
            nb_reg        <= '0;
            again_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            nb_reg        <= nb_next;
            again_reg     <= (state_reg == sgdr_pkg::ST_NB_WR ||
                              state_reg == sgdr_pkg::ST_NB_RD) && last_cell &&
                             nb_reg == sgdr_pkg::NB_DOWN ? 1'b1 : again_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hres_reg      <= hres_next;
        drop_addr_reg <= drop_addr_next;
        rsp_reg       <= rsp_next;
    end

endmodule
`default_nettype wire

### design/sgdr_checker.sv
`default_nettype none
module sgdr_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire sgdr_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire sgdr_pkg::rsp_t rsp
);

    // A request that is not taken stays offered with the same payload.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed before transfer");

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before transfer");

    // One item at a time: no second transfer in the cycle after one.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    // Every valid result reports a height of 0 to 3.
    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.height_out < 4'd4)
        else $error("read height out of stable range");

    // A result carries a height or a count, never both.
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.height_out != '0 |-> rsp.topple_count == '0)
        else $error("height and count both set");

endmodule

bind sandpile_grain_drop_relax_unit sgdr_checker u_sgdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
